@@ rtl/lcdns_pkg.sv @@
// Shared types, command constants and the byte table for the LCD nibble sequencer.
package lcdns_pkg;

  localparam int unsigned INIT_LEN      = 30;
  localparam int unsigned STEP_W        = $clog2(INIT_LEN);
  localparam int unsigned LINES_DEF     = 3;
  localparam int unsigned COLUMNS_DEF   = 16;
  localparam logic [3:0]  CONTRAST_RST  = 4'd11;

  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_CURSOR_ON  = 8'h0F;
  localparam logic [7:0] CMD_CURSOR_OFF = 8'h0C;
  localparam logic [7:0] CMD_EXT_SET    = 8'h29;
  localparam logic [7:0] CMD_NORM_SET   = 8'h28;
  localparam logic [3:0] CMD_CONTRAST_H = 4'h7;
  localparam logic [3:0] NIB_WAKE       = 4'h2;

  // Position of the contrast triple in the init byte table.
  localparam logic [3:0] SEQ_CONTRAST   = 4'd9;

  typedef enum logic [2:0] {
    MODE_INIT       = 3'd0,
    MODE_CMD        = 3'd1,
    MODE_DATA       = 3'd2,
    MODE_POS        = 3'd3,
    MODE_CONTRAST   = 3'd4,
    MODE_CLEAR      = 3'd5,
    MODE_CURSOR_ON  = 3'd6,
    MODE_CURSOR_OFF = 3'd7
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] byte_value;
    logic [1:0] line;
    logic [4:0] column;
    logic [4:0] contrast_level;
  } request_t;

  typedef struct packed {
    logic       action;
    logic [3:0] nibble;
    logic       reg_select;
    logic       read_not_write;
    logic       last;
  } lcd_event_t;

  // Setup commands of init, then the contrast triple.
  function automatic logic [7:0] seq_byte(input logic [3:0] k, input logic [3:0] level);
    logic [7:0] b;
    case (k)
      4'd0:    b = 8'h29;
      4'd1:    b = 8'h15;
      4'd2:    b = 8'h54;
      4'd3:    b = 8'h6E;
      4'd4:    b = 8'h7B;
      4'd5:    b = 8'h28;
      4'd6:    b = 8'h0F;
      4'd7:    b = 8'h01;
      4'd8:    b = 8'h06;
      4'd9:    b = CMD_EXT_SET;
      4'd10:   b = {CMD_CONTRAST_H, level};
      4'd11:   b = CMD_NORM_SET;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/char_lcd_nibble_sequencer_top.sv @@
// Top level of the LCD nibble sequencer: request register, step counter, output word register.
//
//  channel | valid / stall        | payload
//  --------+----------------------+----------------------------------------------------
//  request | req_valid / req_stall| mode, byte_value, line, column, contrast_level
//  event   | evt_valid / evt_stall| action, nibble, reg_select, read_not_write, last
//  config  | cfg_wr_en            | cfg_wr_data (init_contrast)
//
// One event word leaves per cycle while the output is not stalled and a request is held;
// a request has 2 events for a byte, 6 for contrast, 30 for init and none if rejected.
// The step counter over the held request counts those events. The next request is
// taken in the cycle its predecessor's last word enters the output register.
// rst is synchronous and clears the valids, the step counter and init_contrast (11).
// An output stall holds the output word and the step count.
module char_lcd_nibble_sequencer_top
  import lcdns_pkg::*;
#(
  parameter int unsigned LINES   = LINES_DEF,
  parameter int unsigned COLUMNS = COLUMNS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [2:0] mode,
  input  logic [7:0] byte_value,
  input  logic [1:0] line,
  input  logic [4:0] column,
  input  logic [4:0] contrast_level,
  output logic       evt_valid,
  input  logic       evt_stall,
  output logic       action,
  output logic [3:0] nibble,
  output logic       reg_select,
  output logic       read_not_write,
  output logic       last
);

  logic [3:0]        init_contrast;
  logic              hold_valid;
  request_t          hold;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  lcd_event_t        evt_cur;
  lcd_event_t        evt_reg;
  logic              empty;
  logic              out_take;
  logic              fire;
  logic              done;
  logic              req_accept;

  lcdns_event_gen #(
    .LINES   (LINES),
    .COLUMNS (COLUMNS)
  ) u_gen (
    .req           (hold),
    .step          (step),
    .init_contrast (init_contrast),
    .evt           (evt_cur),
    .empty         (empty)
  );

  assign out_take   = ~evt_valid | ~evt_stall;
  assign fire       = hold_valid & ~empty & out_take;
  assign done       = hold_valid & (empty | (out_take & evt_cur.last));
  assign req_stall  = hold_valid & ~done;
  assign req_accept = req_valid & ~req_stall;

  always_comb begin
    if (done || !hold_valid) begin
      step_next = '0;
    end else if (fire) begin
      step_next = step + STEP_W'(1);
    end else begin
      step_next = step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_contrast <= CONTRAST_RST;
      hold_valid    <= 1'b0;
      step          <= '0;
      evt_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        init_contrast <= cfg_wr_data;
      end
      if (!hold_valid || done) begin
        hold_valid <= req_valid;
      end
      step <= step_next;
      if (out_take) begin
        evt_valid <= fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_accept) begin
      hold <= '{mode: mode_t'(mode), byte_value: byte_value, line: line,
                column: column, contrast_level: contrast_level};
    end
    if (fire) begin
      evt_reg <= evt_cur;
    end
  end

  assign action         = evt_reg.action;
  assign nibble         = evt_reg.nibble;
  assign reg_select     = evt_reg.reg_select;
  assign read_not_write = evt_reg.read_not_write;
  assign last           = evt_reg.last;

`ifndef SYNTH
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> step <= STEP_W'(INIT_LEN - 1))
    else $error("step count past the end of the init run");

  a_step_idle: assert property (@(posedge clk) disable iff (rst)
    !hold_valid |-> step == '0)
    else $error("step count not cleared while idle");

  a_step_restart: assert property (@(posedge clk) disable iff (rst)
    req_accept |=> step == '0)
    else $error("new request did not start at step zero");

  a_reset_pulse: assert property (@(posedge clk) disable iff (rst)
    (evt_valid && !action) |-> (!last && nibble == 4'h0 && !reg_select && !read_not_write))
    else $error("reset pulse word carries data or ends the run");
`endif

endmodule

@@ rtl/lcdns_event_gen.sv @@
// Decodes the held request and step count into one pin event.
module lcdns_event_gen
  import lcdns_pkg::*;
#(
  parameter int unsigned LINES   = LINES_DEF,
  parameter int unsigned COLUMNS = COLUMNS_DEF
) (
  input  request_t          req,
  input  logic [STEP_W-1:0] step,
  input  logic [3:0]        init_contrast,
  output lcd_event_t        evt,
  output logic              empty
);

  logic [STEP_W-1:0] init_ofs;
  logic [3:0]        k;
  logic [3:0]        level;
  logic [7:0]        byte_out;
  logic              high_half;
  logic              pos_bad;

  assign init_ofs = step - STEP_W'(6);
  assign pos_bad  = ({1'b0, req.line} >= 3'(LINES)) || (req.column >= 5'(COLUMNS));

  always_comb begin
    k         = '0;
    level     = req.contrast_level[3:0];
    byte_out  = req.byte_value;
    high_half = ~step[0];
    empty     = 1'b0;
    evt       = '{action: 1'b1, nibble: 4'h0, reg_select: 1'b0,
                  read_not_write: 1'b0, last: step[0]};
    unique case (req.mode)
      MODE_INIT: begin
        level     = init_contrast;
        k         = init_ofs[4:1];
        high_half = ~init_ofs[0];
        byte_out  = seq_byte(k, level);
        evt.last  = (step == STEP_W'(INIT_LEN - 1));
      end
      MODE_CMD: begin
        byte_out = req.byte_value;
      end
      MODE_DATA: begin
        byte_out       = req.byte_value;
        evt.reg_select = 1'b1;
      end
      MODE_POS: begin
        byte_out = {2'b10, req.line, req.column[3:0]};
        empty    = pos_bad;
      end
      MODE_CONTRAST: begin
        k        = SEQ_CONTRAST + {2'b00, step[2:1]};
        byte_out = seq_byte(k, level);
        evt.last = (step == STEP_W'(5));
        empty    = req.contrast_level[4];
      end
      MODE_CLEAR:      byte_out = CMD_CLEAR;
      MODE_CURSOR_ON:  byte_out = CMD_CURSOR_ON;
      MODE_CURSOR_OFF: byte_out = CMD_CURSOR_OFF;
    endcase

    evt.nibble = high_half ? byte_out[7:4] : byte_out[3:0];

    // Init opens with the reset pulse, wake strobes and busy reads.
    if (req.mode == MODE_INIT) begin
      if (step == '0) begin
        evt.action = 1'b0;
        evt.nibble = 4'h0;
      end else if (step <= STEP_W'(3)) begin
        evt.nibble = NIB_WAKE;
      end else if (step <= STEP_W'(5)) begin
        evt.nibble         = 4'h0;
        evt.reg_select     = 1'b1;
        evt.read_not_write = 1'b1;
      end
    end
  end

endmodule
